FILE: rtl/spfd_pkg.sv
// ----------------------------------------------------------------------------
// spfd_pkg
// Types and constants for the sensor pulse frame decoder.
// ----------------------------------------------------------------------------
package spfd_pkg;

	typedef logic [2:0] status_t;
	typedef logic [5:0] count_t;
	typedef logic [2:0] reg_idx_t;

	localparam status_t ST_OK    = 3'd0;
	localparam status_t ST_UNDER = 3'd1;
	localparam status_t ST_OVER  = 3'd2;
	localparam status_t ST_NACK  = 3'd3;
	localparam status_t ST_BAD   = 3'd4;
	localparam status_t ST_SUM   = 3'd5;
	localparam status_t ST_NONE  = 3'd0;

	localparam count_t COUNT_SAT   = 6'd44;
	localparam count_t MIN_SYMBOLS = 6'd42;
	localparam count_t MAX_SYMBOLS = 6'd43;
	localparam count_t ACK_SYMBOL  = 6'd1;
	localparam count_t FIRST_DATA  = 6'd2;

	localparam int PADDR_W = 5;

	localparam reg_idx_t REG_SENSOR_KIND   = 3'd0;
	localparam reg_idx_t REG_ACK_MIN       = 3'd1;
	localparam reg_idx_t REG_ACK_MAX       = 3'd2;
	localparam reg_idx_t REG_BIT_LOW_MIN   = 3'd3;
	localparam reg_idx_t REG_BIT_LOW_MAX   = 3'd4;
	localparam reg_idx_t REG_BIT_HIGH_MIN  = 3'd5;
	localparam reg_idx_t REG_BIT_HIGH_MAX  = 3'd6;
	localparam reg_idx_t REG_ONE_THRESHOLD = 3'd7;

	localparam logic        RST_SENSOR_KIND   = 1'b1;
	localparam logic [15:0] RST_ACK_MIN       = 16'd130;
	localparam logic [15:0] RST_ACK_MAX       = 16'd180;
	localparam logic [14:0] RST_BIT_LOW_MIN   = 15'd40;
	localparam logic [14:0] RST_BIT_LOW_MAX   = 15'd60;
	localparam logic [14:0] RST_BIT_HIGH_MIN  = 15'd15;
	localparam logic [14:0] RST_BIT_HIGH_MAX  = 15'd90;
	localparam logic [14:0] RST_ONE_THRESHOLD = 15'd40;

endpackage

FILE: rtl/sensor_pulse_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// sensor_pulse_frame_decoder_unit
// Decodes a 40-bit pulse-width sensor frame into status, humidity and
// temperature, one captured symbol per transaction.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake          | Payload
// in      | sink      | in_valid/in_stall  | low_time, high_time, frame_end
// out     | source    | out_valid/out_stall| frame_status, humidity_tenths,
//         |           |                    | temperature_tenths
// cfg     | sink      | APB, pready tied 1 | 8 registers at 4*i
//
// One symbol per cycle unless a stalled result holds the input. A symbol waits in
// the input register, and a final symbol's frame result is registered as it leaves.
// Reset returns registers to defaults and clears the frame state.
// A stalled result only holds up a final symbol; other symbols keep flowing.
// ----------------------------------------------------------------------------
module sensor_pulse_frame_decoder_unit #(
	parameter int DURATION_BITS = 15
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [DURATION_BITS-1:0]        low_time,
	input  logic [DURATION_BITS-1:0]        high_time,
	input  logic                            frame_end,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [2:0]                      frame_status,
	output logic [15:0]                     humidity_tenths,
	output logic signed [15:0]              temperature_tenths,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [spfd_pkg::PADDR_W-1:0]    paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	// configuration
	logic        sensor_kind_q;
	logic [15:0] ack_min_q;
	logic [15:0] ack_max_q;
	logic [14:0] bit_low_min_q;
	logic [14:0] bit_low_max_q;
	logic [14:0] bit_high_min_q;
	logic [14:0] bit_high_max_q;
	logic [14:0] one_threshold_q;

	spfd_pkg::reg_idx_t reg_idx;
	logic               cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[spfd_pkg::PADDR_W-1:2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_kind_q   <= spfd_pkg::RST_SENSOR_KIND;
			ack_min_q       <= spfd_pkg::RST_ACK_MIN;
			ack_max_q       <= spfd_pkg::RST_ACK_MAX;
			bit_low_min_q   <= spfd_pkg::RST_BIT_LOW_MIN;
			bit_low_max_q   <= spfd_pkg::RST_BIT_LOW_MAX;
			bit_high_min_q  <= spfd_pkg::RST_BIT_HIGH_MIN;
			bit_high_max_q  <= spfd_pkg::RST_BIT_HIGH_MAX;
			one_threshold_q <= spfd_pkg::RST_ONE_THRESHOLD;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				spfd_pkg::REG_SENSOR_KIND:   sensor_kind_q   <= pwdata[0];
				spfd_pkg::REG_ACK_MIN:       ack_min_q       <= pwdata[15:0];
				spfd_pkg::REG_ACK_MAX:       ack_max_q       <= pwdata[15:0];
				spfd_pkg::REG_BIT_LOW_MIN:   bit_low_min_q   <= pwdata[14:0];
				spfd_pkg::REG_BIT_LOW_MAX:   bit_low_max_q   <= pwdata[14:0];
				spfd_pkg::REG_BIT_HIGH_MIN:  bit_high_min_q  <= pwdata[14:0];
				spfd_pkg::REG_BIT_HIGH_MAX:  bit_high_max_q  <= pwdata[14:0];
				spfd_pkg::REG_ONE_THRESHOLD: one_threshold_q <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			spfd_pkg::REG_SENSOR_KIND:   prdata = {31'd0, sensor_kind_q};
			spfd_pkg::REG_ACK_MIN:       prdata = {16'd0, ack_min_q};
			spfd_pkg::REG_ACK_MAX:       prdata = {16'd0, ack_max_q};
			spfd_pkg::REG_BIT_LOW_MIN:   prdata = {17'd0, bit_low_min_q};
			spfd_pkg::REG_BIT_LOW_MAX:   prdata = {17'd0, bit_low_max_q};
			spfd_pkg::REG_BIT_HIGH_MIN:  prdata = {17'd0, bit_high_min_q};
			spfd_pkg::REG_BIT_HIGH_MAX:  prdata = {17'd0, bit_high_max_q};
			spfd_pkg::REG_ONE_THRESHOLD: prdata = {17'd0, one_threshold_q};
			default:                     prdata = 32'd0;
		endcase
	end

	// input register
	logic                     vld_s1;
	logic [DURATION_BITS-1:0] low_s1;
	logic [DURATION_BITS-1:0] high_s1;
	logic                     end_s1;
	logic                     adv;
	logic                     out_valid_q;

	assign adv      = vld_s1 & ~(end_s1 & out_valid_q & out_stall);
	assign in_stall = vld_s1 & ~adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			low_s1  <= low_time;
			high_s1 <= high_time;
			end_s1  <= frame_end;
		end
	end

	// frame state
	spfd_pkg::count_t  count_q;
	logic [39:0]       shift_q;
	spfd_pkg::status_t err_q;

	logic [15:0] lo_w;
	logic [15:0] hi_w;
	logic [16:0] ack_sum;
	logic        ack_bad;
	logic        bit_bad;
	logic        is_data;

	spfd_pkg::count_t  count_nx;
	logic [39:0]       shift_nx;
	spfd_pkg::status_t err_nx;

	assign lo_w    = 16'(low_s1);
	assign hi_w    = 16'(high_s1);
	assign ack_sum = 17'(lo_w) + 17'(hi_w);
	assign ack_bad = (ack_sum < {1'b0, ack_min_q}) || (ack_sum > {1'b0, ack_max_q});
	assign bit_bad = (lo_w < {1'b0, bit_low_min_q}) || (lo_w > {1'b0, bit_low_max_q})
		|| (hi_w < {1'b0, bit_high_min_q}) || (hi_w > {1'b0, bit_high_max_q});
	assign is_data = (count_q >= spfd_pkg::FIRST_DATA) && (count_q < spfd_pkg::MIN_SYMBOLS);

	always_comb begin
		err_nx   = err_q;
		shift_nx = shift_q;
		if (count_q == spfd_pkg::ACK_SYMBOL) begin
			if (ack_bad && err_q == spfd_pkg::ST_NONE)
				err_nx = spfd_pkg::ST_NACK;
		end else if (is_data && err_q == spfd_pkg::ST_NONE) begin
			if (bit_bad)
				err_nx = spfd_pkg::ST_BAD;
			else
				shift_nx = {shift_q[38:0], hi_w > {1'b0, one_threshold_q}};
		end
		count_nx = (count_q < spfd_pkg::COUNT_SAT) ? count_q + 6'd1 : count_q;
	end

	// frame result
	logic [7:0]        b0, b1, b2, b3, b4;
	logic [7:0]        csum;
	logic [14:0]       mag;
	spfd_pkg::status_t status_nx;
	logic [15:0]       hum_nx;
	logic [15:0]       temp_nx;

	assign b0   = shift_nx[39:32];
	assign b1   = shift_nx[31:24];
	assign b2   = shift_nx[23:16];
	assign b3   = shift_nx[15:8];
	assign b4   = shift_nx[7:0];
	assign csum = b0 + b1 + b2 + b3;
	assign mag  = {b2[6:0], b3};

	always_comb begin
		hum_nx  = 16'd0;
		temp_nx = 16'd0;
		if (count_nx < spfd_pkg::MIN_SYMBOLS) begin
			status_nx = spfd_pkg::ST_UNDER;
		end else if (count_nx > spfd_pkg::MAX_SYMBOLS) begin
			status_nx = spfd_pkg::ST_OVER;
		end else if (err_nx != spfd_pkg::ST_NONE) begin
			status_nx = err_nx;
		end else if (csum != b4) begin
			status_nx = spfd_pkg::ST_SUM;
		end else begin
			status_nx = spfd_pkg::ST_OK;
			if (sensor_kind_q) begin
				hum_nx  = {b0, b1};
				temp_nx = b2[7] ? 16'd0 - {1'b0, mag} : {1'b0, mag};
			end else begin
				hum_nx  = 16'(b0) * 16'd10;
				temp_nx = 16'(b2) * 16'd10;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			shift_q <= '0;
			err_q   <= spfd_pkg::ST_NONE;
		end else if (adv) begin
			if (end_s1) begin
				count_q <= '0;
				shift_q <= '0;
				err_q   <= spfd_pkg::ST_NONE;
			end else begin
				count_q <= count_nx;
				shift_q <= shift_nx;
				err_q   <= err_nx;
			end
		end
	end

	// result register
	spfd_pkg::status_t status_q;
	logic [15:0]       hum_q;
	logic [15:0]       temp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && end_s1) begin
			status_q <= status_nx;
			hum_q    <= hum_nx;
			temp_q   <= temp_nx;
		end
	end

	assign out_valid          = out_valid_q;
	assign frame_status       = status_q;
	assign humidity_tenths    = hum_q;
	assign temperature_tenths = temp_q;

endmodule

FILE: sim/spfd_tb_pkg.sv
// ----------------------------------------------------------------------------
// spfd_tb_pkg
// Frame decode predictor and result scoreboard for the pulse frame decoder
// testbench. Each accepted symbol transaction advances a private copy of the
// frame state; each closing symbol queues the status and readings that the
// block must return, and returned results are checked in order.
// ----------------------------------------------------------------------------
package spfd_tb_pkg;

	import spfd_pkg::*;

	typedef struct packed {
		status_t     status;
		logic [15:0] humidity;
		logic [15:0] temperature;
	} frame_result_t;

	class frame_scoreboard;

		logic        kind;
		logic [15:0] ack_min;
		logic [15:0] ack_max;
		logic [14:0] low_min;
		logic [14:0] low_max;
		logic [14:0] high_min;
		logic [14:0] high_max;
		logic [14:0] one_thr;

		count_t      count;
		logic [39:0] bits;
		status_t     first_err;

		frame_result_t pending[$];
		int            errors;

		function new();
			kind      = RST_SENSOR_KIND;
			ack_min   = RST_ACK_MIN;
			ack_max   = RST_ACK_MAX;
			low_min   = RST_BIT_LOW_MIN;
			low_max   = RST_BIT_LOW_MAX;
			high_min  = RST_BIT_HIGH_MIN;
			high_max  = RST_BIT_HIGH_MAX;
			one_thr   = RST_ONE_THRESHOLD;
			count     = '0;
			bits      = '0;
			first_err = ST_NONE;
			errors    = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [31:0] value);
			case (idx)
				REG_SENSOR_KIND:   kind     = value[0];
				REG_ACK_MIN:       ack_min  = value[15:0];
				REG_ACK_MAX:       ack_max  = value[15:0];
				REG_BIT_LOW_MIN:   low_min  = value[14:0];
				REG_BIT_LOW_MAX:   low_max  = value[14:0];
				REG_BIT_HIGH_MIN:  high_min = value[14:0];
				REG_BIT_HIGH_MAX:  high_max = value[14:0];
				REG_ONE_THRESHOLD: one_thr  = value[14:0];
				default: ;
			endcase
		endfunction

		// one accepted symbol transaction
		function void note_symbol(logic [14:0] lo, logic [14:0] hi, logic last);
			logic [16:0]   ack_sum;
			logic [7:0]    b0, b1, b2, b3, b4;
			logic [14:0]   mag;
			frame_result_t r;
			ack_sum = 17'(lo) + 17'(hi);
			if (count == ACK_SYMBOL) begin
				if ((ack_sum < {1'b0, ack_min} || ack_sum > {1'b0, ack_max})
						&& first_err == ST_NONE)
					first_err = ST_NACK;
			end else if (count >= FIRST_DATA && count < MIN_SYMBOLS && first_err == ST_NONE) begin
				if (lo < low_min || lo > low_max || hi < high_min || hi > high_max)
					first_err = ST_BAD;
				else
					bits = {bits[38:0], hi > one_thr};
			end
			if (count < COUNT_SAT)
				count++;
			if (!last)
				return;
			r = '0;
			{b0, b1, b2, b3, b4} = bits;
			if (count < MIN_SYMBOLS) begin
				r.status = ST_UNDER;
			end else if (count > MAX_SYMBOLS) begin
				r.status = ST_OVER;
			end else if (first_err != ST_NONE) begin
				r.status = first_err;
			end else if (8'(b0 + b1 + b2 + b3) != b4) begin
				r.status = ST_SUM;
			end else begin
				r.status = ST_OK;
				if (kind) begin
					mag           = {b2[6:0], b3};
					r.humidity    = {b0, b1};
					r.temperature = b2[7] ? 16'(-{1'b0, mag}) : {1'b0, mag};
				end else begin
					r.humidity    = 16'(b0 * 10);
					r.temperature = 16'(b2 * 10);
				end
			end
			pending.push_back(r);
			count     = '0;
			bits      = '0;
			first_err = ST_NONE;
		endfunction

		function void check_result(status_t st, logic [15:0] hum, logic [15:0] temp);
			frame_result_t e;
			if (pending.size() == 0) begin
				$error("frame result with none pending: frame_status %0d", st);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (st !== e.status) begin
				$error("frame_status: expected %0d, got %0d", e.status, st);
				errors++;
			end
			if (hum !== e.humidity) begin
				$error("humidity_tenths: expected %0d, got %0d", e.humidity, hum);
				errors++;
			end
			if (temp !== e.temperature) begin
				$error("temperature_tenths: expected %0d, got %0d",
					$signed(e.temperature), $signed(temp));
				errors++;
			end
		endfunction

	endclass

endpackage

FILE: sim/tb_sensor_pulse_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_sensor_pulse_frame_decoder_unit
// Regression for the sensor pulse frame decoder. Drives captured symbol
// transactions (well-formed frames with random content, nack, bad data,
// bad checksum, short, long and noise frames) under several register
// settings, with random idling on both channels and a long result hold-off
// that back-pressures the input. Every frame result is predicted and
// checked field by field.
// ----------------------------------------------------------------------------
module tb_sensor_pulse_frame_decoder_unit;

	timeunit 1ns;
	timeprecision 1ps;

	import spfd_pkg::*;
	import spfd_tb_pkg::*;

	typedef enum {FR_OK, FR_SUM, FR_NACK, FR_BAD, FR_SHORT, FR_LONG, FR_NOISE} frame_kind_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [14:0]           low_time;
	logic [14:0]           high_time;
	logic                  frame_end;
	logic                  out_valid;
	logic                  out_stall;
	logic [2:0]            frame_status;
	logic [15:0]           humidity_tenths;
	logic signed [15:0]    temperature_tenths;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [PADDR_W-1:0]    paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	frame_scoreboard sb;
	bit              no_gap;
	bit              no_stall;
	int              hold_off;
	int              accepted_symbols;

	sensor_pulse_frame_decoder_unit dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic send_symbol(logic [14:0] lo, logic [14:0] hi, logic last);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		low_time  <= lo;
		high_time <= hi;
		frame_end <= last;
		do @(posedge clk); while (in_stall);
		sb.note_symbol(lo, hi, last);
		accepted_symbols++;
	endtask

	// lowers valid and waits until every predicted result has been returned
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending.size() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(reg_idx_t idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, value);
	endtask

	task automatic configure(logic kind, logic [15:0] amin, logic [15:0] amax,
			logic [14:0] lmin, logic [14:0] lmax, logic [14:0] hmin,
			logic [14:0] hmax, logic [14:0] thr);
		apb_write(REG_SENSOR_KIND, 32'(kind));
		apb_write(REG_ACK_MIN, 32'(amin));
		apb_write(REG_ACK_MAX, 32'(amax));
		apb_write(REG_BIT_LOW_MIN, 32'(lmin));
		apb_write(REG_BIT_LOW_MAX, 32'(lmax));
		apb_write(REG_BIT_HIGH_MIN, 32'(hmin));
		apb_write(REG_BIT_HIGH_MAX, 32'(hmax));
		apb_write(REG_ONE_THRESHOLD, 32'(thr));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// high duration inside the window that decodes as the wanted bit, if any
	function automatic int data_high(logic one);
		int lo_b, hi_b;
		if (one) begin
			lo_b = (sb.high_min > sb.one_thr + 1) ? sb.high_min : sb.one_thr + 1;
			hi_b = sb.high_max;
		end else begin
			lo_b = sb.high_min;
			hi_b = (sb.high_max < sb.one_thr) ? sb.high_max : sb.one_thr;
		end
		if (lo_b > hi_b) begin
			lo_b = sb.high_min;
			hi_b = sb.high_max;
		end
		return $urandom_range(lo_b, hi_b);
	endfunction

	task automatic send_frame(frame_kind_t k);
		int          len, bad_pos, s;
		logic [7:0]  b [5];
		logic [39:0] word;
		logic [14:0] lo, hi;
		case (k)
			FR_SHORT: len = $urandom_range(1, 41);
			FR_LONG:  len = $urandom_range(44, 64);
			default:  len = 42 + $urandom_range(0, 1);
		endcase
		bad_pos = $urandom_range(2, 41);
		for (int j = 0; j < 4; j++)
			b[j] = 8'($urandom);
		b[4] = b[0] + b[1] + b[2] + b[3];
		if (k == FR_SUM)
			b[4] = b[4] + 8'($urandom_range(1, 255));
		word = {b[0], b[1], b[2], b[3], b[4]};
		for (int i = 0; i < len; i++) begin
			lo = 15'($urandom);
			hi = 15'($urandom);
			if (k != FR_NOISE) begin
				if (i == 1) begin
					if (k != FR_NACK)
						s = $urandom_range(sb.ack_min, sb.ack_max);
					else if (sb.ack_min > 0 && ($urandom_range(0, 1) || sb.ack_max >= 65534))
						s = $urandom_range(0, sb.ack_min - 1);
					else if (sb.ack_max < 65534)
						s = $urandom_range(sb.ack_max + 1, 65534);
					else
						s = $urandom_range(0, 65534);
					lo = 15'($urandom_range(s > 32767 ? s - 32767 : 0, s < 32767 ? s : 32767));
					hi = 15'(s - lo);
				end else if (i >= 2 && i < 42 && !(k == FR_BAD && i > bad_pos)) begin
					lo = 15'($urandom_range(sb.low_min, sb.low_max));
					hi = 15'(data_high(word[41-i]));
					if (k == FR_BAD && i == bad_pos) begin
						case ($urandom_range(0, 3))
							0: if (sb.low_min > 0) lo = 15'($urandom_range(0, sb.low_min - 1));
							1: if (sb.low_max < 32767)
								lo = 15'($urandom_range(sb.low_max + 1, 32767));
							2: if (sb.high_min > 0) hi = 15'($urandom_range(0, sb.high_min - 1));
							default: if (sb.high_max < 32767)
								hi = 15'($urandom_range(sb.high_max + 1, 32767));
						endcase
					end
				end
			end
			send_symbol(lo, hi, i == len - 1);
		end
	endtask

	task automatic run_phase();
		int          first_item, frames, r;
		frame_kind_t k;
		no_gap     = ($urandom_range(0, 3) == 0);
		no_stall   = ($urandom_range(0, 3) == 0);
		first_item = accepted_symbols;
		frames     = 0;
		while (accepted_symbols - first_item < 50 || frames < 1) begin
			r = $urandom_range(0, 99);
			k = r < 35 ? FR_OK : r < 45 ? FR_SUM : r < 55 ? FR_NACK : r < 65 ? FR_BAD :
				r < 85 ? FR_SHORT : r < 93 ? FR_LONG : FR_NOISE;
			send_frame(k);
			frames++;
		end
		settle();
	endtask

	// result side: random stalls, or one long hold-off when asked
	initial begin
		int n;
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_off > 0 && !held) begin
				n    = hold_off;
				held = 1'b1;
			end else begin
				n = no_stall ? 0 : $urandom_range(0, 12);
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			sb.check_result(frame_status, humidity_tenths, temperature_tenths);
		end
	end

	initial begin
		#2000000;
		$display("sensor_pulse_frame_decoder_unit regression: fail");
		$finish;
	end

	initial begin
		logic [15:0] amin;
		logic [14:0] lmin, hmin;
		sb               = new();
		accepted_symbols = 0;
		hold_off         = 0;
		no_gap           = 1'b0;
		no_stall         = 1'b0;
		arst_n           = 1'b0;
		in_valid  <= 1'b0;
		low_time  <= '0;
		high_time <= '0;
		frame_end <= 1'b0;
		out_stall <= 1'b0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field extremes, alternating bit patterns, frames restarting early
		send_symbol(15'h0000, 15'h0000, 1'b1);
		send_symbol(15'h7FFF, 15'h7FFF, 1'b1);
		send_symbol(15'h5555, 15'h2AAA, 1'b0);
		send_symbol(15'h2AAA, 15'h5555, 1'b1);
		send_symbol(15'h7FFF, 15'h0000, 1'b0);
		send_symbol(15'd65, 15'd65, 1'b0);
		send_symbol(15'd50, 15'd70, 1'b0);
		send_symbol(15'd50, 15'd20, 1'b1);
		send_symbol(15'h0000, 15'h7FFF, 1'b0);
		send_symbol(15'h7FFF, 15'h7FFF, 1'b0);
		send_symbol(15'd0, 15'd0, 1'b0);
		send_symbol(15'h7FFF, 15'h7FFF, 1'b1);
		settle();

		// long result hold-off while single-symbol frames keep coming
		hold_off = 300;
		no_gap   = 1'b1;
		repeat (40) send_symbol(15'($urandom), 15'($urandom), 1'b1);
		settle();
		no_gap = 1'b0;

		run_phase();
		configure(1'b0, 16'd130, 16'd180, 15'd40, 15'd60, 15'd15, 15'd90, 15'd40);
		run_phase();
		configure(1'b1, 16'd0, 16'd65534, 15'd0, 15'd32767, 15'd0, 15'd32767, 15'd0);
		run_phase();
		configure(1'b0, 16'd0, 16'd65534, 15'd0, 15'd32767, 15'd0, 15'd32767, 15'd32767);
		run_phase();
		// inverted windows
		configure(1'b1, 16'd200, 16'd100, 15'd60, 15'd40, 15'd90, 15'd15, 15'd40);
		run_phase();
		configure(1'b1, 16'd150, 16'd150, 15'd50, 15'd50, 15'd20, 15'd80, 15'd50);
		run_phase();
		amin = 16'($urandom_range(0, 65534));
		lmin = 15'($urandom);
		hmin = 15'($urandom);
		configure(1'($urandom_range(0, 1)), amin, 16'($urandom_range(amin, 65534)),
			lmin, 15'($urandom_range(lmin, 32767)), hmin, 15'($urandom_range(hmin, 32767)),
			15'($urandom));
		run_phase();
		configure(1'b1, 16'd130, 16'd180, 15'd40, 15'd60, 15'd15, 15'd90, 15'd40);
		run_phase();

		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("sensor_pulse_frame_decoder_unit regression: pass");
		else
			$display("sensor_pulse_frame_decoder_unit regression: fail");
		$finish;
	end

endmodule
